// ===== rtl/rme_pkg.sv =====
package rme_pkg;

  localparam int unsigned DefCordicSteps  = 16;
  localparam int unsigned DefElementWidth = 16;
  localparam int unsigned TableLen        = 24;
  localparam int unsigned PreShift        = 16;
  localparam int unsigned ThrWidth        = 15;
  localparam int unsigned ZWidth          = 28;
  localparam int unsigned AddrWidth       = 3;

  localparam logic [AddrWidth-1:0] RegThreshold = 3'd0;
  localparam logic [ThrWidth-1:0]  ThrReset     = 15'd1;

  localparam logic signed [ZWidth-1:0] HalfPiQ24 = 28'sd26353589;
  localparam logic signed [15:0]       PiQ13     = 16'sd25736;
  localparam logic signed [15:0]       HalfPiQ13 = 16'sd12868;

  // Arctangent of 2^-i in units of 2^-24 rad.
  function automatic logic signed [ZWidth-1:0] atan_entry(input int unsigned idx);
    logic signed [ZWidth-1:0] val;
    unique case (idx)
      0: val = 28'sd13176795;
      1: val = 28'sd7778716;
      2: val = 28'sd4110060;
      3: val = 28'sd2086331;
      4: val = 28'sd1047214;
      5: val = 28'sd524117;
      6: val = 28'sd262123;
      7: val = 28'sd131069;
      default: val = (idx < TableLen) ? (28'sd1 <<< (24 - idx)) : 28'sd0;
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/rme_sqrt.sv =====
// Pipelined restoring square root: one result bit per stage.
module rme_sqrt
  import rme_pkg::*;
#(
  parameter int unsigned InWidth = 2 * DefElementWidth,
  parameter int unsigned OutWidth = InWidth / 2
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [InWidth-1:0]  rad_i,
  output logic [OutWidth-1:0] root_o
);
  localparam int unsigned RemW = OutWidth + 2;

  logic [InWidth-1:0]  rad_q  [OutWidth+1];
  logic [RemW-1:0]     rem_q  [OutWidth+1];
  logic [OutWidth-1:0] root_q [OutWidth+1];

  assign rad_q[0]  = rad_i;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;

  for (genvar s = 0; s < OutWidth; s++) begin : g_stage
    logic [RemW-1:0]     rem_sh;
    logic [RemW-1:0]     trial;
    logic [RemW-1:0]     rem_d;
    logic [OutWidth-1:0] root_d;
    always_comb begin
      rem_sh = {rem_q[s][RemW-3:0], rad_q[s][InWidth-1 -: 2]};
      trial  = {root_q[s], 2'b01};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[s][OutWidth-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[s][OutWidth-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[s+1]  <= rad_q[s] << 2;
        rem_q[s+1]  <= rem_d;
        root_q[s+1] <= root_d;
      end
    end
  end

  assign root_o = root_q[OutWidth];
endmodule

// ===== rtl/rme_atan2.sv =====
// Pipelined vectoring CORDIC atan2 with right half plane fold and Q3.13 rounding.
module rme_atan2
  import rme_pkg::*;
#(
  parameter int unsigned Steps = DefCordicSteps,
  parameter int unsigned InW   = DefElementWidth + 2
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [InW-1:0] y_i,
  input  logic signed [InW-1:0] x_i,
  input  logic signed [15:0]    lim_i,
  output logic signed [15:0]    ang_o
);
  localparam int unsigned W = InW + PreShift + 3;

  logic signed [W-1:0]      x_q [Steps+1];
  logic signed [W-1:0]      y_q [Steps+1];
  logic signed [ZWidth-1:0] z_q [Steps+1];
  logic signed [15:0]       lim_q [Steps+1];
  logic                     zero_q [Steps+1];

  // Fold into the right half plane and pre-scale.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      lim_q[0]  <= lim_i;
      if (x_i < 0) begin
        if (y_i >= 0) begin
          x_q[0] <= W'(y_i) <<< PreShift;
          y_q[0] <= (-W'(x_i)) <<< PreShift;
          z_q[0] <= HalfPiQ24;
        end else begin
          x_q[0] <= (-W'(y_i)) <<< PreShift;
          y_q[0] <= W'(x_i) <<< PreShift;
          z_q[0] <= -HalfPiQ24;
        end
      end else begin
        x_q[0] <= W'(x_i) <<< PreShift;
        y_q[0] <= W'(y_i) <<< PreShift;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < Steps; i++) begin : g_step
    localparam logic signed [ZWidth-1:0] Ang = atan_entry(i);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        lim_q[i+1]  <= lim_q[i];
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + Ang;
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - Ang;
        end
      end
    end
  end

  // Round half up to Q3.13 and clamp.
  logic signed [ZWidth-1:0] zr;
  logic signed [ZWidth-12:0] rs;
  always_comb begin
    zr = z_q[Steps] + ZWidth'(1024);
    rs = zr[ZWidth-1:11];
    if (zero_q[Steps]) ang_o = '0;
    else if (rs > (ZWidth-11)'(lim_q[Steps])) ang_o = lim_q[Steps];
    else if (rs < -(ZWidth-11)'(lim_q[Steps])) ang_o = -lim_q[Steps];
    else ang_o = rs[15:0];
  end
endmodule

// ===== rtl/rotation_matrix_to_euler_unit.sv =====
// Rotation matrix to XYZ Euler angles, fully pipelined.
// Pipeline: ELEMENT_WIDTH+1 square root stages plus CORDIC_STEPS+1 CORDIC stages
// plus one output register.
// Throughput: one matrix per cycle; a stall freezes the whole pipeline.
// Reset clears valid bits and sets the threshold register to 1.
module rotation_matrix_to_euler_unit
  import rme_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS  = DefCordicSteps,
  parameter int unsigned ELEMENT_WIDTH = DefElementWidth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic signed [ELEMENT_WIDTH-1:0] m00_i,
  input  logic signed [ELEMENT_WIDTH-1:0] m10_i,
  input  logic signed [ELEMENT_WIDTH-1:0] m20_i,
  input  logic signed [ELEMENT_WIDTH-1:0] m11_i,
  input  logic signed [ELEMENT_WIDTH-1:0] m12_i,
  input  logic signed [ELEMENT_WIDTH-1:0] m21_i,
  input  logic signed [ELEMENT_WIDTH-1:0] m22_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic signed [15:0] roll_angle_o,
  output logic signed [14:0] pitch_angle_o,
  output logic signed [15:0] yaw_angle_o,
  output logic is_singular_o
);
  localparam int unsigned Ew   = ELEMENT_WIDTH;
  localparam int unsigned SqW  = 2 * Ew;
  localparam int unsigned RtW  = Ew;
  localparam int unsigned AW   = Ew + 2;
  localparam int unsigned SqD  = RtW;
  localparam int unsigned CoD  = CORDIC_STEPS + 1;
  // Square root takes SqD+1 stages, the CORDIC takes CoD.
  localparam int unsigned Lat  = SqD + 1 + CoD;

  logic [ThrWidth-1:0] thr_q;

  // Configuration register.
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (psel && penable && pwrite && (paddr == {RegThreshold[AddrWidth-1:2], 2'b00})) begin
      thr_q <= pwdata[ThrWidth-1:0];
    end
  end
  assign prdata = (paddr[AddrWidth-1:2] == RegThreshold[AddrWidth-1:2]) ?
                  32'(thr_q) : 32'd0;

  // Pipeline advances when output register is free or being drained.
  logic en;
  logic [Lat-1:0] vld_q;
  assign en = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      out_valid_o <= 1'b0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
      out_valid_o <= vld_q[Lat-1];
    end
  end

  // Sum of the squares of the m00 and m10 magnitudes.
  logic [Ew-1:0] a0, a1;
  logic [SqW:0] sum;
  assign a0 = m00_i[Ew-1] ? Ew'(-m00_i) : Ew'(m00_i);
  assign a1 = m10_i[Ew-1] ? Ew'(-m10_i) : Ew'(m10_i);
  assign sum = ((SqW+1)'(a0) * (SqW+1)'(a0)) + ((SqW+1)'(a1) * (SqW+1)'(a1));

  logic [RtW:0] sy;
  rme_sqrt #(.InWidth(SqW + 2), .OutWidth(RtW + 1)) u_sqrt (
    .clk_i(clk_i), .en_i(en), .rad_i({1'b0, sum}), .root_o(sy)
  );

  // Delay matrix entries alongside the root.
  logic signed [Ew-1:0] d_q [SqD+1][6];
  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q[0][0] <= m10_i; d_q[0][1] <= m00_i; d_q[0][2] <= m20_i;
      d_q[0][3] <= m11_i; d_q[0][4] <= m12_i; d_q[0][5] <= m21_i;
      for (int s = 1; s <= SqD; s++) d_q[s] <= d_q[s-1];
    end
  end
  logic signed [Ew-1:0] m22_q [SqD+1];
  always_ff @(posedge clk_i) begin
    if (en) begin
      m22_q[0] <= m22_i;
      for (int s = 1; s <= SqD; s++) m22_q[s] <= m22_q[s-1];
    end
  end

  logic signed [Ew-1:0] e10, e00, e20, e11, e12, e21, e22;
  assign e10 = d_q[SqD][0]; assign e00 = d_q[SqD][1]; assign e20 = d_q[SqD][2];
  assign e11 = d_q[SqD][3]; assign e12 = d_q[SqD][4]; assign e21 = d_q[SqD][5];
  assign e22 = m22_q[SqD];

  logic sing;
  assign sing = (RtW + 1 > ThrWidth) ? ((RtW+1)'(thr_q) > sy)
                                     : (ThrWidth'(sy) < thr_q);

  logic signed [AW-1:0] ry, rx, py, px, yy, yx;
  assign ry = sing ? -AW'(e12) : AW'(e21);
  assign rx = sing ? AW'(e11) : AW'(e22);
  assign py = -AW'(e20);
  assign px = AW'(sy);
  assign yy = AW'(e10);
  assign yx = AW'(e00);

  logic sing_q [CoD];
  always_ff @(posedge clk_i) begin
    if (en) begin
      sing_q[0] <= sing;
      for (int s = 1; s < CoD; s++) sing_q[s] <= sing_q[s-1];
    end
  end

  logic signed [15:0] roll, pitch, yaw;
  rme_atan2 #(.Steps(CORDIC_STEPS), .InW(AW)) u_roll (
    .clk_i(clk_i), .en_i(en), .y_i(ry), .x_i(rx), .lim_i(PiQ13), .ang_o(roll));
  rme_atan2 #(.Steps(CORDIC_STEPS), .InW(AW)) u_pitch (
    .clk_i(clk_i), .en_i(en), .y_i(py), .x_i(px), .lim_i(HalfPiQ13), .ang_o(pitch));
  rme_atan2 #(.Steps(CORDIC_STEPS), .InW(AW)) u_yaw (
    .clk_i(clk_i), .en_i(en), .y_i(yy), .x_i(yx), .lim_i(PiQ13), .ang_o(yaw));

  // Output register.
  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_angle_o  <= roll;
      pitch_angle_o <= pitch[14:0];
      yaw_angle_o   <= sing_q[CoD-1] ? 16'sd0 : yaw;
      is_singular_o <= sing_q[CoD-1];
    end
  end
endmodule

// ===== tb/tb_rotation_matrix_to_euler_unit.sv =====
`timescale 1ns / 1ps

module tb_rotation_matrix_to_euler_unit;
  import rme_pkg::*;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m10;
    logic signed [15:0] m20;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } matrix_t;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic               singular;
  } angles_t;

  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles   = 60;
  localparam real Pi = 3.14159265358979;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [15:0] m00_i = '0, m10_i = '0, m20_i = '0, m11_i = '0;
  logic signed [15:0] m12_i = '0, m21_i = '0, m22_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] roll_angle_o;
  logic signed [14:0] pitch_angle_o;
  logic signed [15:0] yaw_angle_o;
  logic is_singular_o;

  matrix_t pending_matrices[$];
  angles_t expected_angles[$];
  logic [14:0] threshold_copy = ThrReset;
  int error_count = 0;
  int cycle_count = 0;
  int quiet_cycles = 0;

  rotation_matrix_to_euler_unit DUT (.*);

  // Clock with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Arctangent of 2^-i in units of 2^-24 rad.
  function automatic longint atan_step(input int idx);
    longint val;
    case (idx)
      0: val = 13176795;
      1: val = 7778716;
      2: val = 4110060;
      3: val = 2086331;
      4: val = 1047214;
      5: val = 524117;
      6: val = 262123;
      7: val = 131069;
      default: val = longint'(1) << (24 - idx);
    endcase
    return val;
  endfunction

  function automatic longint floor_sqrt(input longint num);
    longint root;
    longint bitv;
    root = 0;
    bitv = longint'(1) << 40;
    while (bitv > num) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (num >= root + bitv) begin
        num = num - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Vectoring CORDIC after folding into the right half plane, result in Q3.13.
  function automatic longint cordic_atan2(input longint y, input longint x,
                                          input longint lim);
    longint z, t, xs, ys, r;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = y; y = -x; x = t; z = 26353589;
      end else begin
        t = -y; y = x; x = t; z = -26353589;
      end
    end
    x = x <<< 16;
    y = y <<< 16;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_step(i);
      end else begin
        x -= ys; y += xs; z -= atan_step(i);
      end
    end
    r = (z + 1024) >>> 11;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic angles_t euler_angles(input matrix_t mx);
    longint a0, a1, sy, roll, pitch, yaw;
    angles_t res;
    a0 = longint'(mx.m00);
    a1 = longint'(mx.m10);
    if (a0 < 0) a0 = -a0;
    if (a1 < 0) a1 = -a1;
    sy = floor_sqrt(a0 * a0 + a1 * a1);
    res.singular = (sy < longint'(threshold_copy));
    pitch = cordic_atan2(-longint'(mx.m20), sy, 12868);
    if (!res.singular) begin
      roll = cordic_atan2(longint'(mx.m21), longint'(mx.m22), 25736);
      yaw = cordic_atan2(longint'(mx.m10), longint'(mx.m00), 25736);
    end else begin
      roll = cordic_atan2(-longint'(mx.m12), longint'(mx.m11), 25736);
      yaw = 0;
    end
    res.roll = roll[15:0];
    res.pitch = pitch[14:0];
    res.yaw = yaw[15:0];
    return res;
  endfunction

  function automatic logic signed [15:0] to_q14(input real v);
    return 16'($rtoi(v * 16384.0));
  endfunction

  function automatic real random_angle();
    return ($urandom_range(0, 65535) / 65535.0 * 2.0 - 1.0) * Pi;
  endfunction

  // Mostly proper rotations, some near gimbal lock, the rest raw noise.
  function automatic matrix_t random_matrix();
    matrix_t mx;
    real a, b, c;
    int span;
    a = random_angle();
    b = random_angle() / 2.0;
    c = random_angle();
    mx.m00 = to_q14($cos(b) * $cos(c));
    mx.m10 = to_q14($cos(b) * $sin(c));
    mx.m20 = to_q14(-$sin(b));
    mx.m11 = to_q14($sin(a) * $sin(b) * $sin(c) + $cos(a) * $cos(c));
    mx.m12 = to_q14($cos(a) * $sin(b) * $sin(c) - $sin(a) * $cos(c));
    mx.m21 = to_q14($sin(a) * $cos(b));
    mx.m22 = to_q14($cos(a) * $cos(b));
    case ($urandom_range(0, 9))
      0, 1: begin
        span = 2 * int'(threshold_copy) + 4;
        mx.m00 = 16'($urandom_range(0, 2 * span) - span);
        mx.m10 = 16'($urandom_range(0, 2 * span) - span);
        mx.m20 = ($urandom_range(0, 1) != 0) ? 16'sd16384 : -16'sd16384;
      end
      2: mx = matrix_t'(112'({$urandom, $urandom, $urandom, $urandom}));
      3: begin
        mx.m00 = 16'($urandom_range(0, 32768) - 16384);
        mx.m10 = 16'($urandom_range(0, 32768) - 16384);
        mx.m20 = 16'($urandom_range(0, 32768) - 16384);
        mx.m11 = 16'($urandom_range(0, 32768) - 16384);
        mx.m12 = 16'($urandom_range(0, 32768) - 16384);
        mx.m21 = 16'($urandom_range(0, 32768) - 16384);
        mx.m22 = 16'($urandom_range(0, 32768) - 16384);
      end
      default: ;
    endcase
    return mx;
  endfunction

  function automatic matrix_t fill_matrix(input logic signed [15:0] v);
    return {v, v, v, v, v, v, v};
  endfunction

  // Append one request to the pending list.
  task automatic add_request(input matrix_t mx);
    pending_matrices = {pending_matrices, mx};
  endtask

  // Setup phase, then access phase; the register takes the value at the access edge.
  task automatic write_threshold(input logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= RegThreshold;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    threshold_copy = value[14:0];
  endtask

  task automatic wait_drained();
    while (pending_matrices.size() != 0 || expected_angles.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic queue_random(input int count);
    repeat (count) add_request(random_matrix());
  endtask

  // Quiet window: no idling on either side.
  function automatic bit idle_now();
    if (cycle_count > 3000 && cycle_count < 3800) return 1'b0;
    return $urandom_range(0, 99) < 20;
  endfunction

  // Request driver: holds a stalled request, otherwise presents the next one.
  always @(posedge clk_i) begin
    matrix_t mx;
    bit taken;
    taken = in_valid_i && !in_stall_o;
    cycle_count <= cycle_count + 1;
    if (taken) begin
      mx = pending_matrices.pop_front();
      expected_angles = {expected_angles, euler_angles(mx)};
    end
    if (rst_ni && !(in_valid_i && !taken)) begin
      if (pending_matrices.size() != 0 && !idle_now()) begin
        mx = pending_matrices[0];
        in_valid_i <= 1'b1;
        m00_i <= mx.m00; m10_i <= mx.m10; m20_i <= mx.m20; m11_i <= mx.m11;
        m12_i <= mx.m12; m21_i <= mx.m21; m22_i <= mx.m22;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result monitor with random back pressure.
  always @(posedge clk_i) begin
    angles_t exp_a;
    if (out_valid_o && !out_stall_i) begin
      if (expected_angles.size() == 0) begin
        $error("result with no request outstanding");
        error_count++;
      end else begin
        exp_a = expected_angles.pop_front();
        if (roll_angle_o !== exp_a.roll) begin
          $error("roll_angle expected %0d actual %0d", exp_a.roll, roll_angle_o);
          error_count++;
        end
        if (pitch_angle_o !== exp_a.pitch) begin
          $error("pitch_angle expected %0d actual %0d", exp_a.pitch, pitch_angle_o);
          error_count++;
        end
        if (yaw_angle_o !== exp_a.yaw) begin
          $error("yaw_angle expected %0d actual %0d", exp_a.yaw, yaw_angle_o);
          error_count++;
        end
        if (is_singular_o !== exp_a.singular) begin
          $error("is_singular expected %0b actual %0b", exp_a.singular, is_singular_o);
          error_count++;
        end
      end
    end
    if (rst_ni) out_stall_i <= idle_now();
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("tb_rotation_matrix_to_euler_unit NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [31:0] thresholds[5];
    thresholds = '{32'd0, 32'd16384, 32'd32767, 32'd200, 32'd1};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests at the reset threshold.
    add_request(fill_matrix(16'sd0));
    add_request(fill_matrix(16'sd16384));
    add_request(fill_matrix(-16'sd16384));
    add_request(fill_matrix(16'sh7fff));
    add_request(fill_matrix(16'sh8000));
    add_request(fill_matrix(16'sh5555));
    add_request(fill_matrix(-16'sh5556));
    add_request({16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
                 16'sd0, 16'sd16384});
    // Negative x axis in roll and yaw.
    add_request({-16'sd16384, 16'sd0, 16'sd0, -16'sd16384, 16'sd0,
                 16'sd0, -16'sd16384});
    // Gimbal lock, pitch up and down.
    add_request({16'sd0, 16'sd0, -16'sd16384, 16'sd16384, 16'sd0,
                 16'sd0, 16'sd0});
    add_request({16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd16384,
                 16'sd9000, 16'sd0});
    add_request({16'sd1, 16'sd0, 16'sd16384, -16'sd16384, -16'sd5,
                 -16'sd3, 16'sd0});
    add_request({16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000,
                 16'sh7fff, 16'sh8000});
    add_request({16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd0,
                 -16'sd1, 16'sd0});
    queue_random(100);
    wait_drained();

    foreach (thresholds[k]) begin
      write_threshold(thresholds[k]);
      queue_random(180);
      // Hold the sender until every result is back.
      wait_drained();
      queue_random(180);
      wait_drained();
    end

    if (error_count == 0) begin
      $display("tb_rotation_matrix_to_euler_unit OK");
    end else begin
      $display("tb_rotation_matrix_to_euler_unit NOT OK");
    end
    $finish;
  end

endmodule
